[hw/rtl/dqhr_pkg.sv]
// ----------------------------------------------------------------------------
// dqhr_pkg
// shared types and constants for the deque with half rotate
// ----------------------------------------------------------------------------
package dqhr_pkg;

  // field widths of the streaming items
  localparam int OPCODE_W    = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 11;
  localparam int MID_W       = 10;

  // packed port widths (tdata rounded up to whole bytes)
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = OPCODE_W;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = STATUS_W;

  // default ring depth
  localparam int DEPTH_DEF   = 1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SWAP       = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

[hw/rtl/dqhr_ram.sv]
// ----------------------------------------------------------------------------
// dqhr_ram
// single-write single-read ring store with registered read data
// ----------------------------------------------------------------------------
module dqhr_ram
  import dqhr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/deque_with_half_rotate_core.sv]
// ----------------------------------------------------------------------------
// deque_with_half_rotate_core
// double-ended queue of signed 32-bit values in a circular store, with a
// swap-halves operation that moves the head forward by count/2 places
// ----------------------------------------------------------------------------
//
// channel | direction | tdata                                   | tuser
// --------+-----------+-----------------------------------------+-------------
// in_     | slave     | value_in[31:0]                          | opcode[2:0]
// out_    | master    | value_out[31:0] count_now[42:32]        | status[1:0]
//         |           | middle_pos[52:43], zero pad [55:53]     |
//
// pushes, swaps, errors and unknown opcodes go straight to the output register;
// a pop that finds data passes through S_READ to take the registered read of the ring store
// front index, count and control clear on rst_n; the ring store is not
// cleared, only written entries are ever read
// the result sits in an output register; a new item is taken in the cycle
// the previous result leaves, so out_tready low stalls the input side
// ----------------------------------------------------------------------------
module deque_with_half_rotate_core
  import dqhr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value_in[31:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // opcode[2:0]

  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // value_out, count_now, middle_pos
  output logic [OUT_TUSER_W-1:0] out_tuser   // status[1:0]
);

  // index and count widths follow the ring depth
  localparam int IW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int OUT_PAD = OUT_TDATA_W - (MID_W + COUNT_W + VALUE_W);

  localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_INDEX = IW'(DEPTH - 1);
  localparam logic [IW:0]   DEPTH_WIDE = (IW + 1)'(DEPTH);

  // head position plus an offset, wrapped once around the ring
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] offs);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= DEPTH_WIDE) begin
      sum = sum - DEPTH_WIDE;
    end
    return sum[IW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // output register
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  status_t            out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [MID_W-1:0]   out_mid_r;

  // decoded input item
  opcode_t            op;
  logic [VALUE_W-1:0] value_in;
  logic               in_fire;
  logic               is_empty;
  logic               is_full;

  // per-item results
  status_t            status;
  logic               pop_ok;     // pop whose value comes from the store
  logic [CW:0]        mid_full;
  logic [CW-1:0]      count_m1;

  // ring store access
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;

  assign op       = opcode_t'(in_tuser[OPCODE_W-1:0]);
  assign value_in = in_tdata[VALUE_W-1:0];
  assign in_fire  = in_tvalid && in_tready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == DEPTH_CNT);
  assign count_m1 = count_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && pop_ok) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // handshake outputs: take an item only when the output slot frees up
  always_comb begin
    unique case (state_r)
      S_IDLE:  in_tready = !out_valid_r || out_tready;
      S_READ:  in_tready = 1'b0;
      default: in_tready = 1'b0;
    endcase
  end

  // operation decode, index update and store access
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    status    = ST_OK;
    pop_ok    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;

    unique case (op)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          // step the head back one place, wrapping at zero
          front_nxt = (front_r == '0) ? LAST_INDEX : front_r - 1'b1;
          count_nxt = count_r + 1'b1;
          wr_en     = in_fire;
          wr_addr   = front_nxt;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          wr_en     = in_fire;
          wr_addr   = ring_add(front_r, count_r[IW-1:0]);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          rd_en     = in_fire;
          rd_addr   = front_r;
          front_nxt = ring_add(front_r, IW'(1));
          count_nxt = count_m1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          rd_en     = in_fire;
          rd_addr   = ring_add(front_r, count_m1[IW-1:0]);
          count_nxt = count_m1;
        end
      end
      OP_SWAP: begin
        // middle element becomes the head; no effect for one or no element
        if (count_r > CW'(1)) begin
          front_nxt = ring_add(front_r, IW'(count_r >> 1));
        end
      end
      default: begin
        // unknown opcode: no operation, counts still reported
      end
    endcase

    // 1-based middle position after the operation, zero when empty
    mid_full = (count_nxt == '0) ? '0 : {2'b00, count_nxt[CW-1:1]} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // output valid: set at once unless the value still has to come from the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= !pop_ok;
    end else if (state_r == S_READ) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_value_r  <= '0;
      out_status_r <= status;
      out_count_r  <= COUNT_W'(count_nxt);
      out_mid_r    <= MID_W'(mid_full);
    end else if (state_r == S_READ) begin
      out_value_r  <= rd_data;
    end
  end

  dqhr_ram #(
    .DEPTH   (DEPTH),
    .AW      (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_mid_r, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;

`ifndef NO_ASSERTIONS
  // the ring never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("element count above ring depth");

  // while a pop waits on the store the output slot must be empty
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !out_valid_r)
    else $error("output slot busy during store read");

  // an accepted pop with data always goes through the read state
  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pop_ok |=> state_r == S_READ)
    else $error("pop did not wait for store data");

  // the read state hands over to idle and presents the result
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_IDLE && out_valid_r)
    else $error("store read did not produce a result");

  // no store access without an accepted item
  a_access_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en || rd_en) |-> in_fire)
    else $error("store accessed without an item");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the deque with half rotate: a short table of
// directed items, then random traffic that walks the deque from empty to full
// and back, with bursty input, a stalling receiver and a running prediction
// of every result
// ----------------------------------------------------------------------------
module tb_top;
  import dqhr_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_DIR       = 23;

  // opcodes outside the defined set, answered as no-ops
  localparam logic [OPCODE_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

  // one result item, split into its fields
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [MID_W-1:0]   mid;
  } deque_result_t;

  // one directed row; known marks a result typed in by hand
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  v;
    logic                known;
    deque_result_t       want;
  } dir_row_t;

  typedef enum int {
    RX_ALWAYS,
    RX_TOGGLE,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_t;

  // directed items: empty pops, extremes, small swaps, unused opcodes
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 10'd0}},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 10'd0}},
    '{OP_SWAP,       32'hffff_ffff, 1'b1, '{32'h0, ST_OK,    11'd0, 10'd0}},
    '{OP_UNUSED_5,   32'h1234_5678, 1'b1, '{32'h0, ST_OK,    11'd0, 10'd0}},
    '{OP_PUSH_FRONT, 32'h7fff_ffff, 1'b1, '{32'h0, ST_OK,    11'd1, 10'd1}},
    '{OP_SWAP,       32'h0000_0000, 1'b1, '{32'h0, ST_OK,    11'd1, 10'd1}},
    '{OP_PUSH_BACK,  32'h8000_0000, 1'b1, '{32'h0, ST_OK,    11'd2, 10'd2}},
    '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0, ST_OK,    11'd3, 10'd2}},
    '{OP_PUSH_BACK,  32'hffff_ffff, 1'b1, '{32'h0, ST_OK,    11'd4, 10'd3}},
    '{OP_SWAP,       32'h0000_0000, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{OP_UNUSED_6,   32'hffff_ffff, 1'b0, '0},
    '{OP_UNUSED_7,   32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_SWAP,       32'h0000_0000, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
    '{OP_PUSH_BACK,  32'haaaa_aaaa, 1'b0, '0},
    '{OP_SWAP,       32'h0000_0000, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 10'd0}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // value_in[31:0]
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // opcode[2:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // value_out, count_now, middle_pos
  logic [OUT_TUSER_W-1:0] out_tuser;       // status[1:0]

  // shadow copy of the deque
  logic [VALUE_W-1:0] shadow_ring [DEPTH];
  int                 shadow_head = 0;
  int                 shadow_count = 0;

  deque_result_t      expected_q[$];
  int                 fail_count = 0;
  int                 burst_left = 0;
  bit                 long_hold_req = 1'b0;

  deque_with_half_rotate_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // applies one operation to the shadow deque and returns its result
  function automatic deque_result_t apply_op(input logic [OPCODE_W-1:0] op,
                                             input logic [VALUE_W-1:0] v);
    deque_result_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = v;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_ring[(shadow_head + shadow_count) % DEPTH] = v;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
          shadow_count--;
        end
      end
      OP_SWAP: begin
        // middle element becomes the new head
        if (shadow_count > 1) begin
          shadow_head = (shadow_head + shadow_count / 2) % DEPTH;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_count);
    r.mid   = (shadow_count == 0) ? '0 : MID_W'(shadow_count / 2 + 1);
    return r;
  endfunction

  // weighted opcode choice; what is left after push, pop and unused is swap
  function automatic logic [OPCODE_W-1:0] pick_op(input int push_pct, input int pop_pct,
                                                  input int unused_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    end else if (r < push_pct + pop_pct + unused_pct) begin
      case ($urandom_range(0, 2))
        0:       return OP_UNUSED_5;
        1:       return OP_UNUSED_6;
        default: return OP_UNUSED_7;
      endcase
    end
    return OP_SWAP;
  endfunction

  // mostly full-range random, sometimes the extremes
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // offers one item in bursts with random gaps; called at a rising edge
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v,
                           input logic known, input deque_result_t want);
    deque_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    // the shadow state moves on even where the result is typed in
    predicted = apply_op(op, v);
    expected_q.push_back(known ? want : predicted);
  endtask

  // sender stays quiet until every outstanding result has come back
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int push_pct, input int pop_pct, input int unused_pct);
    send_item(pick_op(push_pct, pop_pct, unused_pct), random_value(), 1'b0, '0);
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : result_sink
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    mode      = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = 400;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_TOGGLE: out_tready <= ~out_tready;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 9) < 8);
          default:   out_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // compares every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    deque_result_t want;
    deque_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value  = out_tdata[31:0];
      got.count  = out_tdata[42:32];
      got.mid    = out_tdata[52:43];
      got.status = status_t'(out_tuser);
      if (expected_q.size() == 0) begin
        $display("%0t: result with none pending, tdata %h tuser %h",
                 $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value_out expected %h got %h", $time, want.value, got.value);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count_now expected %0d got %0d", $time, want.count, got.count);
          fail_count++;
        end
        if (got.mid !== want.mid) begin
          $display("%0t: middle_pos expected %0d got %0d", $time, want.mid, got.mid);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      send_item(DIR_TAB[i].op, DIR_TAB[i].v, DIR_TAB[i].known, DIR_TAB[i].want);
    end

    // balanced mix near empty, many empty pops and short swaps
    for (int i = 0; i < 120; i++) send_random(40, 40, 4);
    pause_until_drained();

    // fill to the top while the receiver holds off for a long stretch
    long_hold_req = 1'b1;
    while (shadow_count < DEPTH) send_random(92, 3, 1);

    // churn at full: pushes are dropped, pops and swaps keep it near the top
    for (int i = 0; i < 80; i++) send_random(50, 30, 5);

    // mostly pops, the head wraps around the ring
    for (int i = 0; i < 150; i++) send_random(10, 80, 3);
    pause_until_drained();

    // short mixed tail
    for (int i = 0; i < 100; i++) send_random(40, 40, 5);

    pause_until_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
